// ===== sv/mmc3mc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmc3mc_pkg: shared types and constants of the multicart bank mapper
// Item kinds, decoded operation codes, queue entry layout, configuration
// bundle and the fixed addresses and values of the banking scheme.
// ----------------------------------------------------------------------------
package mmc3mc_pkg;

  // Kind of an incoming item, as carried in the sideband.
  typedef enum logic [1:0] {
    KIND_WRITE  = 2'd0,
    KIND_TICK   = 2'd1,
    KIND_PRG    = 2'd2,
    KIND_CHR    = 2'd3
  } kind_t;

  // Operation decoded by the front part and carried out by the back part.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_OUTER,
    OP_BANK_SEL,
    OP_BANK_DATA,
    OP_IRQ_COUNT,
    OP_IRQ_RELOAD,
    OP_IRQ_OFF,
    OP_IRQ_ON,
    OP_TICK,
    OP_PRG,
    OP_CHR
  } op_t;

  // One queue entry.
  typedef struct packed {
    op_t        op;
    logic [7:0] data;
    logic [2:0] window;
  } item_t;

  // Configuration registers as seen by the back part.
  typedef struct packed {
    logic [7:0] prg_units;
    logic [7:0] chr_units;
  } cfg_t;

  // Configuration register indexes.
  localparam logic CFG_PRG_UNITS = 1'b0;
  localparam logic CFG_CHR_UNITS = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [7:0] PRG_UNITS_RESET = 8'd8;
  localparam logic [7:0] CHR_UNITS_RESET = 8'd16;

  // CPU address decoding.
  localparam logic [15:0] ADDR_OUTER      = 16'h6000;
  localparam logic [15:0] ADDR_MASK       = 16'hE001;
  localparam logic [15:0] ADDR_BANK_SEL   = 16'h8000;
  localparam logic [15:0] ADDR_BANK_DATA  = 16'h8001;
  localparam logic [15:0] ADDR_IRQ_COUNT  = 16'hC000;
  localparam logic [15:0] ADDR_IRQ_RELOAD = 16'hC001;
  localparam logic [15:0] ADDR_IRQ_OFF    = 16'hE000;
  localparam logic [15:0] ADDR_IRQ_ON     = 16'hE001;

  // Banking constants.
  localparam logic [8:0] LAST_VISIBLE_LINE = 9'd239;
  localparam logic [7:0] PRG_FIXED_LO      = 8'd14;
  localparam logic [7:0] PRG_FIXED_HI      = 8'd15;
  localparam logic [7:0] CHR_PAIR_MASK     = 8'hFE;

  // Widths of the page arithmetic.
  localparam int SUM_W  = 9;
  localparam int PAGE_W = 11;

endpackage

// ===== sv/multicart_mmc3_bank_mapper.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multicart_mmc3_bank_mapper: multicart bank mapper with scanline interrupt
// Outer bank in front of an inner bank-switching scheme; answers program and
// pattern page lookups and counts scanlines for the interrupt.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                 Contents
//  s_*       in         s_tvalid / s_tready       one event or lookup per transfer
//  m_*       out        m_tvalid / m_tready       one result per input transfer
//  APB       in/out     psel, penable, pready=1   ROM size registers at 0x0, 0x4
//
// Writes and ticks are applied directly by the back part. A lookup runs
// through a start, nine steps of the bit-serial remainder unit and the load
// of the result register; no new item is taken until that load.
// Reset is synchronous and active high; it restores the power-on banking.
// The input side stalls only when the two-entry queue is full, the output
// side holds its result until it is transferred.
// ----------------------------------------------------------------------------
module multicart_mmc3_bank_mapper #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  // Input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  // [15:0] address, [23:16] data, [32:24] scanline, [33] rendering,
  // [36:34] window, [39:37] zero
  input  logic [39:0] s_tdata,
  // [1:0] kind
  input  logic [1:0]  s_tuser,
  // Result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  // [10:0] page, [11] irq, [15:12] zero
  output logic [15:0] m_tdata,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mmc3mc_pkg::*;

  cfg_t        cfg;
  logic        q_full;
  logic        q_push;
  item_t       q_in;
  logic        q_valid;
  logic        q_pop;
  item_t       q_out;
  logic [10:0] res_page;
  logic        res_irq;

  // Configuration registers.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prg_units <= PRG_UNITS_RESET;
      cfg.chr_units <= CHR_UNITS_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        CFG_PRG_UNITS: cfg.prg_units <= pwdata[7:0];
        CFG_CHR_UNITS: cfg.chr_units <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  assign prdata = (paddr[2] == CFG_CHR_UNITS) ? {24'd0, cfg.chr_units}
                                              : {24'd0, cfg.prg_units};

  // Front part: accept and classify.
  mmc3mc_front u_front (
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .kind      (s_tuser),
    .address   (s_tdata[15:0]),
    .data      (s_tdata[23:16]),
    .scanline  (s_tdata[32:24]),
    .rendering (s_tdata[33]),
    .window    (s_tdata[36:34]),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (q_in)
  );

  // Queue between the two parts.
  mmc3mc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_item  (q_out)
  );

  // Back part: state, page reduction and results.
  mmc3mc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_item    (q_out),
    .q_pop     (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_page  (res_page),
    .out_irq   (res_irq)
  );

  assign m_tdata = {4'd0, res_irq, res_page};

endmodule

// ===== sv/mmc3mc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmc3mc_front: input acceptance and classification
// Takes items from the input stream while the queue has room and decodes
// each into an operation code with the operands that the back part needs.
// ----------------------------------------------------------------------------
module mmc3mc_front (
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [1:0]          kind,
  input  logic [15:0]         address,
  input  logic [7:0]          data,
  input  logic [8:0]          scanline,
  input  logic                rendering,
  input  logic [2:0]          window,
  input  logic                q_full,
  output logic                q_push,
  output mmc3mc_pkg::item_t   q_item
);
  import mmc3mc_pkg::*;

  logic [15:0] masked_addr;
  op_t         write_op;

  // Handshake towards the queue.
  assign s_tready = !q_full;
  assign q_push   = s_tvalid && !q_full;

  // Decode of a CPU write address.
  always_comb begin
    masked_addr = address & ADDR_MASK;
    write_op    = OP_NONE;
    if (address == ADDR_OUTER) begin
      write_op = OP_OUTER;
    end else if (address[15]) begin
      case (masked_addr)
        ADDR_BANK_SEL:   write_op = OP_BANK_SEL;
        ADDR_BANK_DATA:  write_op = OP_BANK_DATA;
        ADDR_IRQ_COUNT:  write_op = OP_IRQ_COUNT;
        ADDR_IRQ_RELOAD: write_op = OP_IRQ_RELOAD;
        ADDR_IRQ_OFF:    write_op = OP_IRQ_OFF;
        ADDR_IRQ_ON:     write_op = OP_IRQ_ON;
        default:         write_op = OP_NONE;
      endcase
    end
  end

  // Classification by kind; ticks outside the visible area or with
  // rendering off are dropped to no-operations here.
  always_comb begin
    q_item.data   = data;
    q_item.window = window;
    case (kind_t'(kind))
      KIND_WRITE: q_item.op = write_op;
      KIND_TICK: begin
        q_item.op = (scanline <= LAST_VISIBLE_LINE && rendering) ? OP_TICK : OP_NONE;
      end
      KIND_PRG:   q_item.op = OP_PRG;
      default:    q_item.op = OP_CHR;
    endcase
  end

endmodule

// ===== sv/mmc3mc_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmc3mc_queue: short queue between front and back parts
// A small circular buffer of decoded items so that either side may stall
// without holding up the other.
// ----------------------------------------------------------------------------
module mmc3mc_queue #(
  parameter int DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  mmc3mc_pkg::item_t push_item,
  output logic              full,
  input  logic              pop,
  output logic              valid,
  output mmc3mc_pkg::item_t pop_item
);
  import mmc3mc_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  item_t         entries [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] fill;

  assign full     = (fill == CW'(DEPTH));
  assign valid    = (fill != '0);
  assign pop_item = entries[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        fill <= fill + CW'(1);
      end else if (pop && !push) begin
        fill <= fill - CW'(1);
      end
    end
  end

endmodule

// ===== sv/mmc3mc_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmc3mc_back: execution of decoded items
// Holds the banking and interrupt state, applies writes and ticks, and
// reduces lookup sums with a bit-serial remainder unit into the result
// register.
// ----------------------------------------------------------------------------
module mmc3mc_back (
  input  logic              clk,
  input  logic              rst,
  input  mmc3mc_pkg::cfg_t  cfg,
  input  logic              q_valid,
  input  mmc3mc_pkg::item_t q_item,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [10:0]       out_page,
  output logic              out_irq
);
  import mmc3mc_pkg::*;

  localparam int CNT_W = $clog2(SUM_W + 1);

  typedef enum logic {
    S_IDLE,
    S_DIVIDE
  } state_t;

  state_t            state;
  logic [7:0]        bank_select;
  logic              outer_bank;
  logic [7:0]        prg_select [2];
  logic [7:0]        chr_pair [2];
  logic [7:0]        chr_single [4];
  logic              irq_enabled;
  logic [7:0]        irq_count;
  logic [7:0]        irq_reload;

  // Remainder unit registers.
  logic [PAGE_W-1:0] divisor;
  logic [PAGE_W-1:0] remainder;
  logic [SUM_W-1:0]  dividend;
  logic [CNT_W-1:0]  step_cnt;

  logic              out_free;
  logic [2:0]        target;
  logic [1:0]        single_idx;
  logic [7:0]        tick_dec;
  logic              tick_fire;
  logic [7:0]        prg_base;
  logic [2:0]        chr_win;
  logic [SUM_W-1:0]  chr_base;
  logic [SUM_W-1:0]  lookup_sum;
  logic [PAGE_W-1:0] lookup_mod;
  logic [PAGE_W:0]   trial;
  logic [PAGE_W:0]   trial_sub;
  logic              start_div;
  logic              div_done;
  logic              res_load;

  assign out_free = !out_valid || out_ready;
  assign q_pop    = (state == S_IDLE) && q_valid && out_free;

  // Write target and interrupt counter step.
  always_comb begin
    target     = bank_select[2:0];
    single_idx = 2'(target - 3'd2);
    tick_dec   = irq_count - 8'd1;
    tick_fire  = irq_enabled && (tick_dec == 8'd0);
  end

  // Window to base page, outer bank offset and modulus.
  always_comb begin
    case (q_item.window[1:0])
      2'd0:    prg_base = bank_select[6] ? PRG_FIXED_LO : prg_select[0];
      2'd1:    prg_base = prg_select[1];
      2'd2:    prg_base = bank_select[6] ? prg_select[0] : PRG_FIXED_LO;
      default: prg_base = PRG_FIXED_HI;
    endcase
    chr_win = q_item.window ^ {bank_select[7], 2'b00};
    if (!chr_win[2]) begin
      chr_base = {1'b0, chr_pair[chr_win[1]]} + {8'd0, chr_win[0]};
    end else begin
      chr_base = {1'b0, chr_single[chr_win[1:0]]};
    end
    if (q_item.op == OP_PRG) begin
      lookup_sum = {4'd0, outer_bank, 4'd0} + {1'b0, prg_base};
      lookup_mod = {2'd0, cfg.prg_units, 1'b0};
    end else begin
      lookup_sum = {1'b0, outer_bank, 7'd0} + chr_base;
      lookup_mod = {cfg.chr_units, 3'd0};
    end
  end

  // A lookup with a non-zero modulus goes through the remainder unit; every
  // other popped item, and the end of a reduction, loads the result register.
  always_comb begin
    start_div = q_pop && (q_item.op == OP_PRG || q_item.op == OP_CHR)
                && (lookup_mod != '0);
    div_done  = (state == S_DIVIDE) && (step_cnt == CNT_W'(SUM_W)) && out_free;
    res_load  = (q_pop && !start_div) || div_done;
  end

  // One restoring step: bring in the next dividend bit, subtract if it fits.
  always_comb begin
    trial     = {remainder, dividend[SUM_W-1]};
    trial_sub = trial - {1'b0, divisor};
  end

  // Sequencer, banking state and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      bank_select   <= '0;
      outer_bank    <= 1'b0;
      prg_select[0] <= 8'd0;
      prg_select[1] <= 8'd1;
      chr_pair[0]   <= 8'd0;
      chr_pair[1]   <= 8'd2;
      chr_single[0] <= 8'd4;
      chr_single[1] <= 8'd5;
      chr_single[2] <= 8'd6;
      chr_single[3] <= 8'd7;
      irq_enabled   <= 1'b0;
      irq_count     <= '0;
      irq_reload    <= '0;
    end else begin
      // The result flag is set on a load and cleared on a transfer.
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_pop) begin
            if (!start_div) begin
              out_page <= '0;
              out_irq  <= (q_item.op == OP_TICK) && tick_fire;
            end
            case (q_item.op)
              OP_OUTER:      outer_bank  <= q_item.data[0];
              OP_BANK_SEL:   bank_select <= q_item.data;
              OP_BANK_DATA: begin
                if (target[2:1] == 2'b11) begin
                  prg_select[target[0]] <= q_item.data;
                end else if (cfg.chr_units != 8'd0) begin
                  if (target[2:1] == 2'b00) begin
                    chr_pair[target[0]] <= q_item.data & CHR_PAIR_MASK;
                  end else begin
                    chr_single[single_idx] <= q_item.data;
                  end
                end
              end
              OP_IRQ_COUNT:  irq_count   <= q_item.data;
              OP_IRQ_RELOAD: irq_reload  <= q_item.data;
              OP_IRQ_OFF:    irq_enabled <= 1'b0;
              OP_IRQ_ON:     irq_enabled <= 1'b1;
              OP_TICK: begin
                if (irq_enabled) begin
                  irq_count <= tick_fire ? irq_reload : tick_dec;
                end
              end
              OP_PRG, OP_CHR: begin
                // A zero modulus answers page 0 at once.
                if (start_div) begin
                  divisor   <= lookup_mod;
                  dividend  <= lookup_sum;
                  remainder <= '0;
                  step_cnt  <= '0;
                  state     <= S_DIVIDE;
                end
              end
              default: ;
            endcase
          end
        end
        S_DIVIDE: begin
          if (step_cnt != CNT_W'(SUM_W)) begin
            remainder <= trial_sub[PAGE_W] ? trial[PAGE_W-1:0] : trial_sub[PAGE_W-1:0];
            dividend  <= {dividend[SUM_W-2:0], 1'b0};
            step_cnt  <= step_cnt + CNT_W'(1);
          end else if (div_done) begin
            out_page  <= remainder;
            out_irq   <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
